// ----- design/rtc_date_to_epoch_seconds_macros.svh -----
// Assertion macros shared by the checker of rtc_date_to_epoch_seconds.
// Depends on nothing; included by the checker file.
`ifndef RTC_DATE_TO_EPOCH_SECONDS_MACROS_SVH
`define RTC_DATE_TO_EPOCH_SECONDS_MACROS_SVH

// Same-cycle implication, quiet while reset is applied.
`define RTCDE_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is applied.
`define RTCDE_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- design/rtcde_pkg.sv -----
// Types and constants for the date to epoch seconds converter.
// Depends on nothing; imported by every module of the block.
package rtcde_pkg;

  typedef struct packed {
    logic [7:0] year_since_2000;
    logic [3:0] month_of_year;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } rtcde_in_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic        year_out_of_range;
  } rtcde_out_t;

  localparam logic [31:0] SecsLeapYear   = 32'd31622400;
  localparam logic [31:0] SecsCommonYear = 32'd31536000;
  localparam logic [31:0] SecsPerDay     = 32'd86400;
  localparam logic [31:0] SecsPerHour    = 32'd3600;
  localparam logic [31:0] SecsPerMinute  = 32'd60;

  // Years from 1970 up to 2000, and the last two-digit year accepted (2099).
  localparam logic [7:0] YearsBefore2000 = 8'd30;
  localparam logic [7:0] LastYearOffset  = 8'd99;
  // 1970 + n is a leap year when the low bits of n equal this value.
  localparam logic [1:0] LeapPhase = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MINUTE,
    ST_SECOND,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_ONE,
    OP_ADD
  } op_e;

  typedef enum logic [2:0] {
    SEL_YEAR,
    SEL_MONTH,
    SEL_DAY,
    SEL_HOUR,
    SEL_MINUTE,
    SEL_SECOND
  } sel_e;

  // Commands from the sequencer to the accumulator.
  typedef struct packed {
    op_e        op;
    sel_e       sel;
    logic [7:0] idx;
    logic       leap;
    logic [5:0] second;
  } acc_ctrl_t;

  // Status from the sequencer to the top level.
  typedef struct packed {
    logic busy;
    logic done;
    logic oor;
  } ctrl_stat_t;

  // Length of month m (0 is January) in seconds.
  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
    logic [31:0] secs;
    unique case (m)
      4'd0:    secs = 32'd2678400;                          // 31 days
      4'd1:    secs = leap ? 32'd2505600 : 32'd2419200;     // 29 or 28 days
      4'd2:    secs = 32'd2678400;
      4'd3:    secs = 32'd2592000;                          // 30 days
      4'd4:    secs = 32'd2678400;
      4'd5:    secs = 32'd2592000;
      4'd6:    secs = 32'd2678400;
      4'd7:    secs = 32'd2678400;
      4'd8:    secs = 32'd2592000;
      4'd9:    secs = 32'd2678400;
      4'd10:   secs = 32'd2592000;
      default: secs = 32'd2678400;
    endcase
    return secs;
  endfunction

endpackage

// ----- design/rtcde_acc.sv -----
// Accumulator with the single shared 32-bit adder of the converter.
// Depends on rtcde_pkg; driven by rtcde_ctrl.
module rtcde_acc import rtcde_pkg::*; (
  input  logic        clk_i,
  input  acc_ctrl_t   ctrl_i,
  output logic [31:0] acc_o
);

  logic [31:0] acc_q, acc_d;
  logic [31:0] operand;

  always_comb begin
    unique case (ctrl_i.sel)
      SEL_YEAR:   operand = (ctrl_i.idx[1:0] == LeapPhase) ? SecsLeapYear : SecsCommonYear;
      SEL_MONTH:  operand = month_secs(ctrl_i.idx[3:0], ctrl_i.leap);
      SEL_DAY:    operand = SecsPerDay;
      SEL_HOUR:   operand = SecsPerHour;
      SEL_MINUTE: operand = SecsPerMinute;
      SEL_SECOND: operand = {26'd0, ctrl_i.second};
      default:    operand = 32'd0;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.op)
      OP_HOLD:  acc_d = acc_q;
      OP_CLEAR: acc_d = 32'd0;
      OP_ONE:   acc_d = 32'd1;
      OP_ADD:   acc_d = acc_q + operand;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ----- design/rtcde_ctrl.sv -----
// Sequencer of the converter: captures a reading and steps the accumulator
// through the year, month, day, hour, minute and second phases.
// Depends on rtcde_pkg; drives rtcde_acc.
module rtcde_ctrl import rtcde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  rtcde_in_t  in_data_i,
  input  logic       out_free_i,
  output acc_ctrl_t  acc_ctrl_o,
  output ctrl_stat_t stat_o
);

  typedef struct packed {
    logic [3:0] months_before;
    logic [4:0] days_before;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       leap;
  } job_t;

  state_e     state_q, state_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] lim_q, lim_d;
  job_t       job_q, job_d;
  logic       oor_q, oor_d;
  logic       last;
  logic [7:0] idx_inc;
  logic       done;
  acc_ctrl_t  ctl;

  assign last    = (idx_q == lim_q);
  assign idx_inc = idx_q + 8'd1;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    lim_d      = lim_q;
    job_d      = job_q;
    oor_d      = oor_q;
    done       = 1'b0;
    ctl.op     = OP_HOLD;
    ctl.sel    = SEL_YEAR;
    ctl.idx    = idx_q;
    ctl.leap   = job_q.leap;
    ctl.second = job_q.second;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // Month zero counts as January and anything above twelve as December.
          if (in_data_i.month_of_year == 4'd0) begin
            job_d.months_before = 4'd0;
          end else if (in_data_i.month_of_year > 4'd12) begin
            job_d.months_before = 4'd11;
          end else begin
            job_d.months_before = in_data_i.month_of_year - 4'd1;
          end
          // Day zero counts as the first of the month.
          if (in_data_i.day_of_month == 5'd0) begin
            job_d.days_before = 5'd0;
          end else begin
            job_d.days_before = in_data_i.day_of_month - 5'd1;
          end
          job_d.hour   = in_data_i.hour_of_day;
          job_d.minute = in_data_i.minute_of_hour;
          job_d.second = in_data_i.second_of_minute;
          job_d.leap   = (in_data_i.year_since_2000[1:0] == 2'd0);
          if (in_data_i.year_since_2000 > LastYearOffset) begin
            oor_d   = 1'b1;
            ctl.op  = OP_ONE;
            state_d = ST_DONE;
          end else begin
            oor_d   = 1'b0;
            ctl.op  = OP_CLEAR;
            idx_d   = 8'd0;
            lim_d   = in_data_i.year_since_2000 + YearsBefore2000;
            state_d = ST_YEAR;
          end
        end
      end
      ST_YEAR: begin
        ctl.sel = SEL_YEAR;
        if (last) begin
          idx_d   = 8'd0;
          lim_d   = {4'd0, job_q.months_before};
          state_d = ST_MONTH;
        end else begin
          ctl.op = OP_ADD;
          idx_d  = idx_inc;
        end
      end
      ST_MONTH: begin
        ctl.sel = SEL_MONTH;
        if (last) begin
          idx_d   = 8'd0;
          lim_d   = {3'd0, job_q.days_before};
          state_d = ST_DAY;
        end else begin
          ctl.op = OP_ADD;
          idx_d  = idx_inc;
        end
      end
      ST_DAY: begin
        ctl.sel = SEL_DAY;
        if (last) begin
          idx_d   = 8'd0;
          lim_d   = {3'd0, job_q.hour};
          state_d = ST_HOUR;
        end else begin
          ctl.op = OP_ADD;
          idx_d  = idx_inc;
        end
      end
      ST_HOUR: begin
        ctl.sel = SEL_HOUR;
        if (last) begin
          idx_d   = 8'd0;
          lim_d   = {2'd0, job_q.minute};
          state_d = ST_MINUTE;
        end else begin
          ctl.op = OP_ADD;
          idx_d  = idx_inc;
        end
      end
      ST_MINUTE: begin
        ctl.sel = SEL_MINUTE;
        if (last) begin
          state_d = ST_SECOND;
        end else begin
          ctl.op = OP_ADD;
          idx_d  = idx_inc;
        end
      end
      ST_SECOND: begin
        ctl.sel = SEL_SECOND;
        ctl.op  = OP_ADD;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done = 1'b1;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      oor_q   <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    lim_q <= lim_d;
    job_q <= job_d;
  end

  assign acc_ctrl_o  = ctl;
  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = done;
  assign stat_o.oor  = oor_q;

endmodule

// ----- design/rtc_date_to_epoch_seconds.sv -----
// Top level of the real-time-clock date to epoch seconds converter.
// Depends on rtcde_pkg, rtcde_ctrl and rtcde_acc.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (rtcde_in_t)
//  out     | output    | out_valid_o/ out_stall_i| out_data_o (rtcde_out_t)
//
// A transaction is captured and then summed on the one shared 32-bit adder: the
// year phase adds one year weight per year from 1970 up to the year of the date,
// the month, day, hour and minute phases add one weight per whole unit before the
// date, each phase with one closing step, and the second phase adds the seconds.
// A year past 2099 finishes with the value 1 and the error flag.
// Reset is asynchronous and active low; it idles the sequencer and empties the
// output register. A stalled result holds the sequencer in its final state.

module rtc_date_to_epoch_seconds import rtcde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  rtcde_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rtcde_out_t out_data_o
);

  acc_ctrl_t   acc_ctrl;
  ctrl_stat_t  stat;
  logic [31:0] acc;
  logic        out_free;
  logic        out_valid_q, out_valid_d;
  rtcde_out_t  out_data_q, out_data_d;

  // The output register can take a result when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  rtcde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .acc_ctrl_o (acc_ctrl),
    .stat_o     (stat)
  );

  rtcde_acc u_acc (
    .clk_i  (clk_i),
    .ctrl_i (acc_ctrl),
    .acc_o  (acc)
  );

  // A new reading is taken only while the sequencer is idle; the output
  // register lets it start while the previous result still waits.
  assign in_stall_o = stat.busy;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (stat.done && out_free) begin
      out_valid_d                  = 1'b1;
      out_data_d.epoch_seconds     = acc;
      out_data_d.year_out_of_range = stat.oor;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/rtcde_chk.sv -----
// Port-level checker for rtc_date_to_epoch_seconds, bound to the top level.
// Depends on rtcde_pkg and rtc_date_to_epoch_seconds_macros.svh.
`include "rtc_date_to_epoch_seconds_macros.svh"

module rtcde_chk import rtcde_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input rtcde_out_t out_data_o
);

  `RTCDE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `RTCDE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "accepted transaction did not occupy the converter")
  `RTCDE_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result appeared one cycle after acceptance")
  `RTCDE_ASSERT_NOW(a_oor_value, clk_i, rst_ni, out_valid_o && out_data_o.year_out_of_range, out_data_o.epoch_seconds == 32'd1, "out-of-range year without value one")

endmodule

bind rtc_date_to_epoch_seconds rtcde_chk u_rtcde_chk (.*);

// ----- test/rtc_date_to_epoch_seconds_tb.sv -----
// Self-checking testbench for the date to epoch seconds converter.
// Depends on rtcde_pkg and the design of rtc_date_to_epoch_seconds; needs no other file.
module rtc_date_to_epoch_seconds_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtcde_pkg::*;

  // Calendar anchors: the epoch starts in 1970 and the clock counts years from 2000.
  localparam int unsigned EpochYear   = 1970;
  localparam int unsigned CenturyBase = 2000;

  // Longest wait that either side draws between two transactions.
  localparam int unsigned MaxWait = 16;
  // Tail long enough to cover the slowest reading, so this covers any stray result.
  localparam int unsigned DrainCycles = 400;
  // Length of the receiver hold-off used to fill the block and stall its input.
  localparam int unsigned LongHoldCycles = 800;
  // Mismatch lines beyond this are counted but not printed.
  localparam int unsigned MaxPrinted = 100;

  // One outstanding result, kept together with the reading that caused it.
  typedef struct packed {
    rtcde_in_t  reading;
    rtcde_out_t result;
  } epoch_expect_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  rtcde_in_t  in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rtcde_out_t out_data_o;

  int unsigned   days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  epoch_expect_t pending_epochs [$];
  int unsigned   mismatch_count   = 0;
  // When set, neither side idles, so transactions run back to back.
  bit            steady_flow      = 1'b0;
  // A non-zero value asks the result process for one long stall of that many cycles.
  int unsigned   hold_off_request = 0;

  rtc_date_to_epoch_seconds dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4ns clk_i = ~clk_i;
  end

  // Expected conversion of one clock reading. Years past 2099 give the value one with
  // the error flag; otherwise whole years, whole months and whole days are summed in
  // seconds and the time of day is added with its plain weights, whatever its range.
  // The sum is kept to 32 bits, as the result field is.
  function automatic rtcde_out_t predict_epoch(input rtcde_in_t rd);
    rtcde_out_t  res;
    logic [31:0] total;
    int unsigned cal_year;
    int unsigned month;
    int unsigned day;

    res      = '0;
    total    = '0;
    cal_year = CenturyBase + 32'(rd.year_since_2000);
    if (rd.year_since_2000 > LastYearOffset) begin
      res.epoch_seconds     = 32'd1;
      res.year_out_of_range = 1'b1;
      return res;
    end
    // Every fourth year is leap, which holds for the whole span up to 2099.
    for (int unsigned y = EpochYear; y < cal_year; y++) begin
      total += (y % 4 == 0) ? SecsLeapYear : SecsCommonYear;
    end
    // Month zero counts as January and anything past December as December.
    month = 32'(rd.month_of_year);
    if (month == 0) month = 1;
    if (month > 12) month = 12;
    for (int unsigned m = 0; m < month - 1; m++) begin
      total += days_in_month[m] * SecsPerDay;
      if (m == 1 && cal_year % 4 == 0) total += SecsPerDay;
    end
    // Day zero counts as the first; days past the month's end are not checked.
    day = (rd.day_of_month == 0) ? 1 : 32'(rd.day_of_month);
    total += (day - 1) * SecsPerDay;
    total += 32'(rd.hour_of_day) * SecsPerHour;
    total += 32'(rd.minute_of_hour) * SecsPerMinute;
    total += 32'(rd.second_of_minute);
    res.epoch_seconds = total;
    return res;
  endfunction

  function automatic rtcde_in_t make_reading(input int unsigned year, input int unsigned month,
                                             input int unsigned day, input int unsigned hour,
                                             input int unsigned minute,
                                             input int unsigned second);
    rtcde_in_t rd;

    rd.year_since_2000  = year[7:0];
    rd.month_of_year    = month[3:0];
    rd.day_of_month     = day[4:0];
    rd.hour_of_day      = hour[4:0];
    rd.minute_of_hour   = minute[5:0];
    rd.second_of_minute = second[5:0];
    return rd;
  endfunction

  // Mostly sensible dates, with a share of readings that push every field to its full
  // width: years past 2099, month zero or above twelve, day zero and oversized times.
  function automatic rtcde_in_t random_reading();
    rtcde_in_t rd;

    rd.year_since_2000  = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(100, 255)
                                                          : $urandom_range(0, 99));
    rd.month_of_year    = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, 12));
    rd.day_of_month     = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(1, 28));
    rd.hour_of_day      = 5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 23));
    rd.minute_of_hour   = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 59));
    rd.second_of_minute = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 59));
    return rd;
  endfunction

  // Idle cycles before the next transaction on either side; at least a quarter of draws
  // are zero so that back-to-back transactions are common even when idling is on.
  function automatic int unsigned draw_wait();
    if (steady_flow) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrinted) $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Offers one reading and returns in the time step in which it was accepted. Valid is
  // only lowered when a gap is drawn, so a back-to-back transaction keeps it high.
  task automatic send_reading(input rtcde_in_t rd);
    int unsigned   gap;
    epoch_expect_t entry;

    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rd;
    do @(posedge clk_i); while (in_stall_o);
    entry.reading = rd;
    entry.result  = predict_epoch(rd);
    pending_epochs.push_back(entry);
  endtask

  // Lets every outstanding result arrive, then a tail long enough for any stray one.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Compares one accepted result with the oldest expectation.
  task automatic check_result(input rtcde_out_t got);
    epoch_expect_t want;

    if (pending_epochs.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0b arrived with nothing outstanding",
                                got.epoch_seconds, got.year_out_of_range));
      return;
    end
    want = pending_epochs.pop_front();
    if (got.epoch_seconds !== want.result.epoch_seconds) begin
      report_mismatch($sformatf("reading %p: epoch_seconds %0d, wanted %0d", want.reading,
                                got.epoch_seconds, want.result.epoch_seconds));
    end
    if (got.year_out_of_range !== want.result.year_out_of_range) begin
      report_mismatch($sformatf("reading %p: year_out_of_range %0b, wanted %0b",
                                want.reading, got.year_out_of_range,
                                want.result.year_out_of_range));
    end
  endtask

  // Result side: checks each accepted transaction and drives the stall. After every
  // result a fresh wait is drawn; a hold-off request replaces it with one long stall,
  // counted down here cycle by cycle while the sender keeps offering readings.
  initial begin : result_sink
    int unsigned sink_wait;

    sink_wait = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        check_result(out_data_o);
        sink_wait = draw_wait();
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      if (hold_off_request != 0) begin
        sink_wait        = hold_off_request;
        hold_off_request = 0;
      end
      out_stall_i <= (sink_wait != 0);
    end
  end

  // Edges of every field and each special case of the conversion.
  task automatic test_directed_dates();
    send_reading(make_reading(0, 1, 1, 0, 0, 0));        // first second of 2000
    send_reading(make_reading(0, 1, 1, 0, 0, 1));
    send_reading(make_reading(0, 2, 29, 12, 30, 30));    // leap day in a leap year
    send_reading(make_reading(0, 3, 1, 0, 0, 0));        // leap day already counted
    send_reading(make_reading(1, 3, 1, 0, 0, 0));        // same date in a common year
    send_reading(make_reading(38, 1, 19, 3, 14, 7));     // around the signed 32-bit limit
    send_reading(make_reading(96, 12, 31, 23, 59, 59));  // last leap year of the range
    send_reading(make_reading(99, 12, 31, 23, 59, 59));  // last valid second
    send_reading(make_reading(99, 2, 29, 0, 0, 0));      // 2099 is common, day rolls over
    send_reading(make_reading(100, 1, 1, 0, 0, 0));      // first year past the range
    send_reading(make_reading(255, 15, 31, 31, 63, 63)); // every bit set
    send_reading(make_reading(128, 0, 0, 0, 0, 0));
    send_reading(make_reading(0, 0, 0, 0, 0, 0));        // month and day zero
    send_reading(make_reading(4, 0, 15, 6, 0, 0));
    send_reading(make_reading(4, 13, 1, 0, 0, 0));       // month above December
    send_reading(make_reading(4, 15, 31, 0, 0, 0));
    send_reading(make_reading(24, 2, 31, 0, 0, 0));      // day past the month's end
    send_reading(make_reading(23, 4, 31, 10, 10, 10));
    send_reading(make_reading(50, 6, 15, 31, 63, 63));   // time of day out of range
    send_reading(make_reading(77, 7, 7, 24, 60, 60));
    send_reading(make_reading(85, 10, 16, 5, 32, 16));
    send_reading(make_reading(99, 1, 1, 0, 0, 0));
    wait_drained();
  endtask

  // The bulk of the run, with both sides idling at random.
  task automatic test_random_dates();
    repeat (1100) send_reading(random_reading());
    wait_drained();
  endtask

  // Back-to-back transactions on both channels with no idling at all.
  task automatic test_steady_flow();
    steady_flow = 1'b1;
    repeat (80) send_reading(random_reading());
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // The receiver stalls for a long stretch while readings keep coming, so the output
  // register fills, the sequencer waits in its final state and the input is stalled.
  task automatic test_output_backpressure();
    hold_off_request = LongHoldCycles;
    steady_flow      = 1'b1;
    repeat (12) send_reading(random_reading());
    steady_flow = 1'b0;
    repeat (36) send_reading(random_reading());
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_dates();
    test_random_dates();
    test_steady_flow();
    test_output_backpressure();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hang: well beyond the slowest correct run of every reading.
  initial begin : watchdog
    #15ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/rtcde_pkg.sv
design/rtcde_acc.sv
design/rtcde_ctrl.sv
design/rtc_date_to_epoch_seconds.sv
design/rtcde_chk.sv
test/rtc_date_to_epoch_seconds_tb.sv
